@@ hw/rtl/timed_priority_rule_table_core_assert.svh @@
// ----------------------------------------------------------------------------
// timed_priority_rule_table_core_assert
// Assertion macros used by the rule table core.
// ----------------------------------------------------------------------------
`ifndef TIMED_PRIORITY_RULE_TABLE_CORE_ASSERT_SVH
`define TIMED_PRIORITY_RULE_TABLE_CORE_ASSERT_SVH

// Expression must never hold out of reset.
`define TPRT_ASSERT_NEVER(label, clk, rst_n, expr) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
    else $error("assertion failed");

// Antecedent in one cycle implies consequent in the next.
`define TPRT_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

@@ hw/rtl/tprt_pkg.sv @@
// ----------------------------------------------------------------------------
// tprt_pkg
// Types and codes of the timed priority rule table.
// ----------------------------------------------------------------------------
package tprt_pkg;

  localparam int TIME_W = 64;

  typedef enum logic [2:0] {
    OP_APPEND    = 3'd0,
    OP_DELETE    = 3'd1,
    OP_CLR_TF    = 3'd2,
    OP_CLR_TYPE  = 3'd3,
    OP_CLR_ALL   = 3'd4,
    OP_LOOKUP    = 3'd5
  } op_e;

  localparam logic [1:0] STATUS_OK      = 2'd0;
  localparam logic [1:0] STATUS_FULL    = 2'd1;
  localparam logic [1:0] STATUS_NODEL   = 2'd2;
  localparam logic [1:0] STATUS_NOMATCH = 2'd3;

  localparam logic [1:0] LEVEL_DEFAULT  = 2'd2;
  localparam logic [1:0] LEVEL_NONE     = 2'd0;

  typedef struct packed {
    logic [1:0] rtype;
    logic [7:0] feature;
    logic [1:0] level;
    logic       ovr;
  } key_t;

  typedef struct packed {
    key_t              key;
    logic [TIME_W-1:0] start;
  } rule_t;

  typedef struct packed {
    op_e               op;
    key_t              key;
    logic [TIME_W-1:0] start;
    logic [TIME_W-1:0] qtime;
  } query_t;

  typedef struct packed {
    logic clear;
    logic step;
  } judge_ctrl_t;

  typedef struct packed {
    logic       drop;
    logic       found;
    logic       dropped_any;
    logic [1:0] level;
  } judge_res_t;

endpackage

@@ hw/rtl/tprt_cell.sv @@
// ----------------------------------------------------------------------------
// tprt_cell
// One rule slot; loads a word or takes the word of its upper neighbor.
// ----------------------------------------------------------------------------
module tprt_cell (
  input  logic           clk_i,
  input  logic           shift_i,
  input  logic           load_i,
  input  tprt_pkg::rule_t load_word_i,
  input  tprt_pkg::rule_t next_word_i,
  output tprt_pkg::rule_t word_o
);
  import tprt_pkg::*;

  rule_t word_q;

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      word_q <= load_word_i;
    end else if (shift_i) begin
      word_q <= next_word_i;
    end
  end

  assign word_o = word_q;

endmodule

@@ hw/rtl/tprt_judge.sv @@
// ----------------------------------------------------------------------------
// tprt_judge
// Head evaluator: drop decision and best-match tracking over a sweep.
// ----------------------------------------------------------------------------
module tprt_judge (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  tprt_pkg::judge_ctrl_t ctrl_i,
  input  tprt_pkg::query_t      query_i,
  input  tprt_pkg::rule_t       head_i,
  output tprt_pkg::judge_res_t  res_o
);
  import tprt_pkg::*;

  query_t            query_q;
  logic              found_q;
  logic              done_q;
  logic              dropped_q;
  logic [1:0]        best_lvl_q;
  logic [TIME_W-1:0] best_start_q;
  logic              drop;
  logic              match;
  logic              same_tf;

  always_comb begin
    same_tf = {head_i.key.rtype, head_i.key.feature} ==
              {query_q.key.rtype, query_q.key.feature};
    match   = same_tf && (head_i.start <= query_q.qtime);
    unique case (query_q.op)
      OP_DELETE:   drop = (head_i.key == query_q.key) && (head_i.start == query_q.start);
      OP_CLR_TF:   drop = same_tf;
      OP_CLR_TYPE: drop = head_i.key.rtype == query_q.key.rtype;
      default:     drop = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.clear) begin
      query_q <= query_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      found_q   <= 1'b0;
      done_q    <= 1'b0;
      dropped_q <= 1'b0;
    end else if (ctrl_i.clear) begin
      found_q   <= 1'b0;
      done_q    <= 1'b0;
      dropped_q <= 1'b0;
    end else if (ctrl_i.step) begin
      if (drop) begin
        dropped_q <= 1'b1;
      end
      if (query_q.op == OP_LOOKUP && match && !done_q) begin
        if (head_i.key.ovr) begin
          found_q <= 1'b1;
          done_q  <= 1'b1;
        end else if (!found_q || best_start_q < head_i.start) begin
          found_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.step && query_q.op == OP_LOOKUP && match && !done_q) begin
      if (head_i.key.ovr) begin
        best_lvl_q <= head_i.key.level;
      end else if (!found_q || best_start_q < head_i.start) begin
        best_lvl_q   <= head_i.key.level;
        best_start_q <= head_i.start;
      end
    end
  end

  assign res_o.drop        = drop;
  assign res_o.found       = found_q;
  assign res_o.dropped_any = dropped_q;
  assign res_o.level       = best_lvl_q;

endmodule

@@ hw/rtl/timed_priority_rule_table_core.sv @@
// ----------------------------------------------------------------------------
// timed_priority_rule_table_core
// Ordered rule table held in a row of cells, one result word per input word.
// ----------------------------------------------------------------------------
// Append, clear all and unused opcodes set the result word in the accepting
// cycle. Delete, the two clears by key and lookup rotate the occupied cells
// once past the single head port of the evaluator, one rule per cycle: the
// accepting cycle, a step per rule and a closing cycle that writes the
// result word.
// The result word sits in an output register; a new word is taken once the
// table is idle and the output register is free or being read.
module timed_priority_rule_table_core #(
  parameter int TABLE_DEPTH = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [2:0]  opcode_i,
  input  logic [1:0]  rule_type_i,
  input  logic [7:0]  feature_id_i,
  input  logic [63:0] from_time_i,
  input  logic [1:0]  rule_level_i,
  input  logic        override_flag_i,
  input  logic [63:0] query_time_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [1:0]  level_out_o,
  output logic [1:0]  status_o,
  output logic [4:0]  entry_count_o
);
  import tprt_pkg::*;

  `include "timed_priority_rule_table_core_assert.svh"

  localparam int CW = $clog2(TABLE_DEPTH + 1);
  localparam logic [CW-1:0] DEPTH_C = CW'(TABLE_DEPTH);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_SCAN = 1'b1;

  logic          state_q, state_d;
  logic [CW-1:0] count_q, count_d;
  logic [CW-1:0] len_q, len_d;
  logic [CW-1:0] rem_q, rem_d;
  logic          out_valid_q, out_valid_d;
  logic [1:0]    level_q, level_d;
  logic [1:0]    status_q, status_d;
  logic [CW-1:0] res_count_q, res_count_d;

  logic          accept;
  logic          scan_step;
  logic          finish;
  op_e           op;
  op_e           op_q;
  key_t          in_key;
  rule_t         in_word;
  rule_t         head;
  rule_t         load_word;
  logic [CW-1:0] load_idx;
  logic          load_en;
  query_t        query;
  judge_ctrl_t   jctrl;
  judge_res_t    jres;
  rule_t         cell_word [TABLE_DEPTH];

  assign op        = op_e'(opcode_i);
  assign in_stall_o = (state_q != ST_IDLE) || (out_valid_q && out_stall_i);
  assign accept    = in_valid_i && !in_stall_o;
  assign scan_step = (state_q == ST_SCAN) && (rem_q != '0);
  assign finish    = (state_q == ST_SCAN) && (rem_q == '0);
  assign head      = cell_word[0];

  assign in_key.rtype   = rule_type_i;
  assign in_key.feature = feature_id_i;
  assign in_key.level   = rule_level_i;
  assign in_key.ovr     = override_flag_i;
  assign in_word.key    = in_key;
  assign in_word.start  = from_time_i;

  assign query.op    = op;
  assign query.key   = in_key;
  assign query.start = from_time_i;
  assign query.qtime = query_time_i;

  assign jctrl.clear = accept;
  assign jctrl.step  = scan_step;

  always_comb begin
    load_en   = 1'b0;
    load_idx  = count_q;
    load_word = in_word;
    if (accept && op == OP_APPEND && count_q != DEPTH_C) begin
      load_en = 1'b1;
    end else if (scan_step && !jres.drop) begin
      load_en   = 1'b1;
      load_idx  = len_q - CW'(1);
      load_word = head;
    end
  end

  for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
    rule_t next_word;
    if (i == TABLE_DEPTH - 1) begin : g_last
      assign next_word = cell_word[i];
    end else begin : g_mid
      assign next_word = cell_word[i + 1];
    end
    tprt_cell u_cell (
      .clk_i       (clk_i),
      .shift_i     (scan_step),
      .load_i      (load_en && (load_idx == CW'(i))),
      .load_word_i (load_word),
      .next_word_i (next_word),
      .word_o      (cell_word[i])
    );
  end

  tprt_judge u_judge (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctrl_i  (jctrl),
    .query_i (query),
    .head_i  (head),
    .res_o   (jres)
  );

  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    len_d       = len_q;
    rem_d       = rem_q;
    out_valid_d = out_valid_q && out_stall_i;
    level_d     = level_q;
    status_d    = status_q;
    res_count_d = res_count_q;
    if (accept) begin
      level_d  = LEVEL_NONE;
      status_d = STATUS_OK;
      unique case (op)
        OP_APPEND: begin
          out_valid_d = 1'b1;
          if (count_q == DEPTH_C) begin
            status_d = STATUS_FULL;
          end else begin
            count_d = count_q + CW'(1);
          end
          res_count_d = (count_q == DEPTH_C) ? count_q : count_q + CW'(1);
        end
        OP_CLR_ALL: begin
          out_valid_d = 1'b1;
          count_d     = '0;
          res_count_d = '0;
        end
        OP_DELETE, OP_CLR_TF, OP_CLR_TYPE, OP_LOOKUP: begin
          state_d = ST_SCAN;
          len_d   = count_q;
          rem_d   = count_q;
        end
        default: begin
          out_valid_d = 1'b1;
          res_count_d = count_q;
        end
      endcase
    end else if (scan_step) begin
      rem_d = rem_q - CW'(1);
      if (jres.drop) begin
        len_d = len_q - CW'(1);
      end
    end else if (finish) begin
      state_d     = ST_IDLE;
      count_d     = len_q;
      out_valid_d = 1'b1;
      res_count_d = len_q;
      level_d     = LEVEL_NONE;
      status_d    = STATUS_OK;
      if (op_q == OP_LOOKUP) begin
        level_d = jres.found ? jres.level : LEVEL_DEFAULT;
        if (!jres.found) begin
          status_d = STATUS_NOMATCH;
        end
      end else if (op_q == OP_DELETE && !jres.dropped_any) begin
        status_d = STATUS_NODEL;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      count_q     <= '0;
      len_q       <= '0;
      rem_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      len_q       <= len_d;
      rem_q       <= rem_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    level_q     <= level_d;
    status_q    <= status_d;
    res_count_q <= res_count_d;
    if (accept) begin
      op_q <= op;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign level_out_o   = level_q;
  assign status_o      = status_q;
  assign entry_count_o = 5'(res_count_q);

  `TPRT_ASSERT_NEVER(a_count_le_depth, clk_i, rst_ni, count_q > DEPTH_C)
  `TPRT_ASSERT_NEVER(a_rem_le_len, clk_i, rst_ni, (state_q == ST_SCAN) && (rem_q > len_q))
  `TPRT_ASSERT_NEXT(a_finish_result, clk_i, rst_ni, finish, out_valid_q && (state_q == ST_IDLE))

endmodule
